// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(name, cond) \
  `ASSERT_CLK(name, !(cond))

`endif

// ===== rtl/hwc_pkg.sv =====
`default_nettype none

package hwc_pkg;

  localparam int unsigned HUE_FRAC  = 6;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DEG_W     = 9;
  localparam int unsigned LVL_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned DIV_CNT_W = 4;

  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [CNT_W-1:0] MAX_WINDOW = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_LOW    = 3'd0,
    REG_SKIP_HIGH   = 3'd1,
    REG_RED_LOW     = 3'd2,
    REG_RED_HIGH    = 3'd3,
    REG_GREEN_LOW   = 3'd4,
    REG_GREEN_HIGH  = 3'd5,
    REG_WINDOW_SIZE = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    VERDICT_SKIP    = 3'd0,
    VERDICT_COUNTED = 3'd1,
    VERDICT_RED     = 3'd2,
    VERDICT_GREEN   = 3'd3,
    VERDICT_NEITHER = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_NUM,
    S_HDIV,
    S_HUE,
    S_ADIV,
    S_CLASS,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
  } in_req_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [2:0]       verdict;
    logic [HUE_W-1:0] average_hue;
  } out_req_t;

  function automatic logic in_band(logic [HUE_W-1:0] h, logic [DEG_W-1:0] lo,
                                   logic [DEG_W-1:0] hi);
    logic [HUE_W-1:0] lo_s;
    logic [HUE_W-1:0] hi_s;
    lo_s = {lo, {HUE_FRAC{1'b0}}};
    hi_s = {hi, {HUE_FRAC{1'b0}}};
    return (h >= lo_s) && (h <= hi_s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hue_window_color_classifier_core.sv =====
`default_nettype none

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+----------------------------------
// in       | in  | in_valid_i / in_ready_o | in_req_i  (red, green, blue)
// out      | out | out_valid_o/out_ready_i | out_req_o (hue, verdict, avg)
// cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time. A counted or skipped sample runs prep, the hue divide
// and the hue step; one that closes the window adds the average divide and the
// class step. Both hue and average come from one shared restoring divider,
// one quotient bit per cycle, 15 bits. Equal channels skip the hue divide.
// Reset is asynchronous; config registers return to their defaults.
// A result waiting on out_ready_i holds the core in its final state.
module hue_window_color_classifier_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  hwc_pkg::in_req_t                    in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hwc_pkg::out_req_t                   out_req_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hwc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hwc_pkg::DEG_W-1:0]           cfg_data_i
);
  import hwc_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic [DEG_W-1:0] skip_low_q, skip_high_q, red_low_q, red_high_q;
  logic [DEG_W-1:0] green_low_q, green_high_q;
  logic [CNT_W-1:0] window_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [LVL_W-1:0] r_q, g_q, b_q;
  sector_e          sector_q, sector_d;
  logic [LVL_W-1:0] diff_q, diff_d;

  logic [LVL_W-1:0]     rem_q, rem_d;
  logic [HUE_W-1:0]     dvd_q, dvd_d;
  logic [LVL_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [HUE_W-1:0] hue_q, hue_d;
  verdict_e         verdict_q, verdict_d;
  logic [HUE_W-1:0] avg_q, avg_d;

  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;

  logic [LVL_W-1:0] mx, mn, a_sel, c_sel;
  logic [DEG_W-1:0] base_deg;
  logic [16:0]      base_mul;
  logic [DEG_W-1:0] dd;
  logic [17:0]      dd_x, dd_60, num_t;
  logic [DEG_W-1:0] trial;
  logic             trial_ge;
  logic [HUE_W-1:0] hue_v;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new, win;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_low_q   <= 9'd240;
      skip_high_q  <= 9'd301;
      red_low_q    <= 9'd310;
      red_high_q   <= 9'd355;
      green_low_q  <= 9'd12;
      green_high_q <= 9'd60;
      window_q     <= 7'd10;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SKIP_LOW:    skip_low_q   <= cfg_data_i;
        REG_SKIP_HIGH:   skip_high_q  <= cfg_data_i;
        REG_RED_LOW:     red_low_q    <= cfg_data_i;
        REG_RED_HIGH:    red_high_q   <= cfg_data_i;
        REG_GREEN_LOW:   green_low_q  <= cfg_data_i;
        REG_GREEN_HIGH:  green_high_q <= cfg_data_i;
        REG_WINDOW_SIZE: window_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      r_q <= in_req_i.red_level;
      g_q <= in_req_i.green_level;
      b_q <= in_req_i.blue_level;
    end
    sector_q  <= sector_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    div_cnt_q <= div_cnt_d;
    hue_q     <= hue_d;
    verdict_q <= verdict_d;
    avg_q     <= avg_d;
    out_q     <= out_d;
  end

  always_comb begin
    // max, min and hue sector; ties go red, then green
    if (r_q >= g_q && r_q >= b_q) begin
      sector_d = SEC_RED;
      mx       = r_q;
    end else if (g_q >= b_q) begin
      sector_d = SEC_GREEN;
      mx       = g_q;
    end else begin
      sector_d = SEC_BLUE;
      mx       = b_q;
    end
    mn = r_q;
    if (g_q < mn) mn = g_q;
    if (b_q < mn) mn = b_q;

    unique case (sector_q)
      SEC_RED: begin
        base_deg = 9'd360;
        a_sel    = g_q;
        c_sel    = b_q;
      end
      SEC_GREEN: begin
        base_deg = 9'd120;
        a_sel    = b_q;
        c_sel    = r_q;
      end
      default: begin
        base_deg = 9'd240;
        a_sel    = r_q;
        c_sel    = g_q;
      end
    endcase
    // num = base * diff + 60 * (a - c), never negative
    base_mul = {9'b0, diff_q} * {8'b0, base_deg};
    dd       = {1'b0, a_sel} - {1'b0, c_sel};
    dd_x     = {{9{dd[DEG_W-1]}}, dd};
    dd_60    = (dd_x << 6) - (dd_x << 2);
    num_t    = {1'b0, base_mul} + dd_60;

    trial    = {rem_q, dvd_q[HUE_W-1]};
    trial_ge = (trial >= {1'b0, dvs_q});

    hue_v    = (dvd_q >= HUE_FULL) ? (dvd_q - HUE_FULL) : dvd_q;
    sum_new  = sum_q + {{(SUM_W-HUE_W){1'b0}}, hue_v};
    cnt_new  = cnt_q + 7'd1;
    if (window_q == '0) begin
      win = 7'd1;
    end else if (window_q > MAX_WINDOW) begin
      win = MAX_WINDOW;
    end else begin
      win = window_q;
    end

    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    div_cnt_d   = div_cnt_q;
    hue_d       = hue_q;
    verdict_d   = verdict_q;
    avg_d       = avg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        diff_d  = mx - mn;
        state_d = S_NUM;
      end
      S_NUM: begin
        if (diff_q == '0) begin
          dvd_d   = '0;
          state_d = S_HUE;
        end else begin
          rem_d     = num_t[16:9];
          dvd_d     = {num_t[8:0], {HUE_FRAC{1'b0}}};
          dvs_d     = diff_q;
          div_cnt_d = DIV_CNT_W'(DIV_STEPS - 1);
          state_d   = S_HDIV;
        end
      end
      S_HDIV, S_ADIV: begin
        rem_d     = trial_ge ? 8'(trial - {1'b0, dvs_q}) : trial[LVL_W-1:0];
        dvd_d     = {dvd_q[HUE_W-2:0], trial_ge};
        div_cnt_d = div_cnt_q - 4'd1;
        if (div_cnt_q == '0) begin
          state_d = (state_q == S_HDIV) ? S_HUE : S_CLASS;
        end
      end
      S_HUE: begin
        hue_d = hue_v;
        avg_d = '0;
        if (in_band(hue_v, skip_low_q, skip_high_q)) begin
          verdict_d = VERDICT_SKIP;
          state_d   = S_DONE;
        end else if (cnt_new != '0 && cnt_new >= win) begin
          // sum < count * 2^15, so the quotient fits 15 bits
          rem_d     = {2'b0, sum_new[SUM_W-1:HUE_W]};
          dvd_d     = sum_new[HUE_W-1:0];
          dvs_d     = {1'b0, cnt_new};
          div_cnt_d = DIV_CNT_W'(DIV_STEPS - 1);
          sum_d     = '0;
          cnt_d     = '0;
          state_d   = S_ADIV;
        end else begin
          sum_d     = sum_new;
          cnt_d     = cnt_new;
          verdict_d = VERDICT_COUNTED;
          state_d   = S_DONE;
        end
      end
      S_CLASS: begin
        avg_d = dvd_q;
        if (in_band(dvd_q, red_low_q, red_high_q)) begin
          verdict_d = VERDICT_RED;
        end else if (in_band(dvd_q, green_low_q, green_high_q)) begin
          verdict_d = VERDICT_GREEN;
        end else begin
          verdict_d = VERDICT_NEITHER;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.hue         = hue_q;
          out_d.verdict     = verdict_q;
          out_d.average_hue = avg_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `ASSERT_CLK(a_accept_starts, in_valid_i && in_ready_o |=> state_q == S_PREP)
  `ASSERT_NEVER(a_count_below_max, cnt_q >= MAX_WINDOW)
  `ASSERT_CLK(a_div_rem_bound, (state_q == S_HDIV || state_q == S_ADIV) |-> rem_q < dvs_q)
  `ASSERT_CLK(a_done_waits, state_q == S_DONE && out_valid_q && !out_ready_i |=>
              state_q == S_DONE)

endmodule

`default_nettype wire
